// ===== sv/bda_pkg.sv =====
// ----------------------------------------------------------------------------
// bda_pkg
// Item types and operation codes shared by the BCD digit ALU modules.
// ----------------------------------------------------------------------------
package bda_pkg;

    // Operation codes carried in the mode field.
    localparam logic [2:0] MODE_BCD_ADD = 3'd0;
    localparam logic [2:0] MODE_BCD_SUB = 3'd1;
    localparam logic [2:0] MODE_BCD_MUL = 3'd2;
    localparam logic [2:0] MODE_EXP_ADD = 3'd3;
    localparam logic [2:0] MODE_EXP_SUB = 3'd4;

    // Excess-128 bias applied to exponent sums and differences.
    localparam logic [7:0] EXP_BIAS = 8'd128;

    // Largest value that is still a single decimal digit.
    localparam logic [4:0] DIGIT_MAX = 5'd9;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] operand_a;
        logic [7:0] operand_b;
        logic       carry_in;
    } op_item_t;

    typedef struct packed {
        logic [7:0] result;
        logic       flag_out;
    } res_item_t;

endpackage

// ===== sv/bda_dabble.sv =====
// ----------------------------------------------------------------------------
// bda_dabble
// Binary to two-digit packed BCD conversion by double dabble.
// ----------------------------------------------------------------------------
module bda_dabble
(
    input  logic [7:0] bin,
    output logic [7:0] bcd
);

    logic [15:0] acc;

    // Eight shift steps; each BCD nibble of five or more gets +3 (4-bit wrap)
    // before the shift. The hundreds digit falls off the top, so a value of
    // 100 or more comes out as its remainder modulo 100.
    always_comb
    begin
        acc = {8'd0, bin};
        for (int i = 0; i < 8; i++)
        begin
            if (acc[11:8] >= 4'd5)
            begin
                acc[11:8] = acc[11:8] + 4'd3;
            end
            if (acc[15:12] >= 4'd5)
            begin
                acc[15:12] = acc[15:12] + 4'd3;
            end
            acc = {acc[14:0], 1'b0};
        end
    end

    assign bcd = acc[15:8];

endmodule

// ===== sv/bda_core.sv =====
// ----------------------------------------------------------------------------
// bda_core
// Combinational datapath: BCD add, subtract and multiply, and exponent
// add and subtract.
// ----------------------------------------------------------------------------
module bda_core
    import bda_pkg::*;
(
    input  op_item_t  op,
    output res_item_t res
);

    logic [3:0] a_dig;
    logic [3:0] b_dig;
    logic [4:0] add_sum;
    logic [4:0] add_adj;
    logic       add_carry;
    logic [5:0] sub_diff;
    logic [5:0] sub_adj;
    logic       sub_borrow;
    logic [7:0] mul_bin;
    logic [7:0] mul_bcd;

    assign a_dig = op.operand_a[3:0];
    assign b_dig = op.operand_b[3:0];

    // Decimal add: correct by +6 when the binary sum passes nine.
    assign add_sum   = {1'b0, a_dig} + {1'b0, b_dig} + {4'd0, op.carry_in};
    assign add_carry = (add_sum > DIGIT_MAX);
    assign add_adj   = add_sum + 5'd6;

    // Decimal subtract, biased by 32 so bit 5 clear means a borrow.
    assign sub_diff   = 6'd32 + {2'd0, a_dig} - {2'd0, b_dig} - {5'd0, op.carry_in};
    assign sub_borrow = ~sub_diff[5];
    assign sub_adj    = sub_diff + 6'd10;

    // A 4 by 4 product never exceeds eight bits.
    assign mul_bin = {4'd0, a_dig} * {4'd0, b_dig};

    bda_dabble u_dabble
    (
        .bin (mul_bin),
        .bcd (mul_bcd)
    );

    always_comb
    begin
        res.result   = 8'd0;
        res.flag_out = 1'b0;
        case (op.mode)
            MODE_BCD_ADD:
            begin
                res.result   = {4'd0, (add_carry ? add_adj[3:0] : add_sum[3:0])};
                res.flag_out = add_carry;
            end
            MODE_BCD_SUB:
            begin
                res.result   = {4'd0, (sub_borrow ? sub_adj[3:0] : sub_diff[3:0])};
                res.flag_out = sub_borrow;
            end
            MODE_BCD_MUL:
            begin
                res.result = mul_bcd;
            end
            MODE_EXP_ADD:
            begin
                res.result = op.operand_a + op.operand_b + EXP_BIAS;
            end
            MODE_EXP_SUB:
            begin
                res.result = op.operand_a - op.operand_b + EXP_BIAS;
            end
            default:
            begin
                res.result   = 8'd0;
                res.flag_out = 1'b0;
            end
        endcase
    end

endmodule

// ===== sv/bcd_digit_alu.sv =====
// ----------------------------------------------------------------------------
// bcd_digit_alu
// Calculator ALU for BCD digits and excess-128 exponents.
// ----------------------------------------------------------------------------
// The block takes one operation item per cycle while op_stall is low and
// returns exactly one result item for it, in order. An accepted item lands
// in the input register, passes through the combinational datapath (a 4 by
// 4 multiplier followed by an eight-step double dabble is the longest path)
// and is caught in the result register, which loads whenever it is empty
// or being read out; the result is offered from there. The sustained rate
// is one item per cycle as long as res_stall stays low and op_valid high.
// The two registers form a two-deep pipeline: a new item is accepted while a
// finished result waits, and op_stall rises only when both registers hold
// items and res_stall is high. BCD modes use only the low nibble of each
// operand; add and subtract return one digit with the carry or borrow in
// flag_out, multiply returns the product modulo 100 as two packed digits,
// and the exponent modes wrap modulo 256 with flag_out low. Codes five to
// seven return zero. The block has no configuration and no other state.
// ----------------------------------------------------------------------------
module bcd_digit_alu
    import bda_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      op_valid,
    output logic      op_stall,
    input  op_item_t  op,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res
);

    logic      s1_valid_reg;
    logic      s1_valid_next;
    op_item_t  s1_item_reg;
    logic      res_valid_reg;
    logic      res_valid_next;
    res_item_t res_item_reg;
    res_item_t core_res;
    logic      res_advance;
    logic      s1_advance;
    logic      op_take;

    // The result register can load when it is empty or being read out.
    assign res_advance = ~res_valid_reg | ~res_stall;
    // The input register can load when it is empty or moving forward.
    assign s1_advance  = ~s1_valid_reg | res_advance;
    assign op_stall    = ~s1_advance;
    assign op_take     = op_valid & s1_advance;

    assign s1_valid_next  = s1_advance ? op_valid : s1_valid_reg;
    assign res_valid_next = res_advance ? s1_valid_reg : res_valid_reg;

    bda_core u_core
    (
        .op  (s1_item_reg),
        .res (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers load only with a valid item moving in.
    always_ff @(posedge clk)
    begin
        if (op_take)
        begin
            s1_item_reg <= op;
        end
        if (res_advance && s1_valid_reg)
        begin
            res_item_reg <= core_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_item_reg;

    // The input side is held back only when both stages are full.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        op_stall |-> (s1_valid_reg && res_valid_reg && res_stall))
        else $error("op_stall raised with room in the pipeline");

    // An accepted item is in the input register on the next cycle.
    a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (op_valid && !op_stall) |=> s1_valid_reg)
        else $error("accepted item did not reach the input register");

    // An item in the input register with an open output is offered next.
    a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && res_advance) |=> res_valid)
        else $error("item in the input register was lost");

endmodule

// ===== tb/sv/bcd_digit_alu_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bcd_digit_alu_tb
// Self-checking testbench for the BCD digit and exponent ALU. Each accepted
// operation item is run through a local model of the datapath, and every
// result item is compared with the oldest prediction. Directed tests cover
// the edges of each operation, then random items run under changing sender
// gaps and receiver stalls.
// ----------------------------------------------------------------------------
module bcd_digit_alu_tb;
    import bda_pkg::*;

    // Codes five to seven have no operation behind them and must return zero.
    localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;

    // Subtraction runs on a value biased by 32 so it never goes negative;
    // a result below the bias means a borrow was taken.
    localparam logic [5:0] SUB_BIAS       = 6'd32;
    localparam logic [5:0] DIGIT_RADIX    = 6'd10;
    localparam logic [4:0] DECIMAL_ADJUST = 5'd6;

    // Double dabble adds three to any BCD nibble that has reached five.
    localparam logic [3:0] DABBLE_LIMIT = 4'd5;
    localparam logic [3:0] DABBLE_ADD   = 4'd3;

    localparam int RANDOM_PER_PHASE = 350;
    localparam int DRAIN_CYCLES     = 8;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int REPORT_LIMIT     = 10;

    logic      clk;
    logic      rst_n;
    logic      op_valid;
    logic      op_stall;
    op_item_t  op;
    logic      res_valid;
    logic      res_stall;
    res_item_t res;

    // Percentages that shape the traffic of the current phase.
    int sender_idle_pct   = 0;
    int receiver_stall_pct = 0;

    // Predictions waiting for their result item, oldest first.
    res_item_t   digit_results_due[$];
    int          fail_count  = 0;
    int unsigned cycle_count = 0;

    bcd_digit_alu uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .op        (op),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always #4 clk = ~clk;

    // Computes the result item that the ALU must return for one operation.
    // Only the low nibbles take part in the BCD operations; the exponent
    // operations use the full bytes and wrap modulo 256.
    function automatic res_item_t expected_digit_result(input op_item_t item);
        logic [3:0]  digit_a;
        logic [3:0]  digit_b;
        logic [4:0]  digit_sum;
        logic [5:0]  digit_diff;
        logic [7:0]  product;
        logic [7:0]  multiplicand;
        logic [3:0]  multiplier;
        logic [15:0] dabble;
        res_item_t   want;
        int          i;
        digit_a = item.operand_a[3:0];
        digit_b = item.operand_b[3:0];
        want    = '0;
        case (item.mode)
            MODE_BCD_ADD:
            begin
                digit_sum     = digit_a + digit_b + item.carry_in;
                want.flag_out = (digit_sum > DIGIT_MAX);
                if (want.flag_out)
                begin
                    digit_sum = digit_sum + DECIMAL_ADJUST;
                end
                want.result = {4'h0, digit_sum[3:0]};
            end
            MODE_BCD_SUB:
            begin
                digit_diff    = {2'b00, digit_a} + SUB_BIAS - digit_b - item.carry_in;
                want.flag_out = (digit_diff < SUB_BIAS);
                if (want.flag_out)
                begin
                    digit_diff = digit_diff + DIGIT_RADIX;
                end
                want.result = {4'h0, digit_diff[3:0]};
            end
            MODE_BCD_MUL:
            begin
                // Shift-and-add over the four multiplier bits.
                product      = '0;
                multiplicand = {4'h0, digit_a};
                multiplier   = digit_b;
                for (i = 0; i < 4; i++)
                begin
                    if (multiplier[0])
                    begin
                        product = product + multiplicand;
                    end
                    multiplier   = multiplier >> 1;
                    multiplicand = multiplicand << 1;
                end
                // Eight dabble steps move the binary product into the upper
                // byte as tens and ones; a hundreds digit falls off the top.
                dabble = {8'h00, product};
                for (i = 0; i < 8; i++)
                begin
                    if (dabble[11:8] >= DABBLE_LIMIT)
                    begin
                        dabble[11:8] = dabble[11:8] + DABBLE_ADD;
                    end
                    if (dabble[15:12] >= DABBLE_LIMIT)
                    begin
                        dabble[15:12] = dabble[15:12] + DABBLE_ADD;
                    end
                    dabble = dabble << 1;
                end
                want.result = dabble[15:8];
            end
            MODE_EXP_ADD:
            begin
                want.result = item.operand_a + item.operand_b + EXP_BIAS;
            end
            MODE_EXP_SUB:
            begin
                want.result = item.operand_a - item.operand_b + EXP_BIAS;
            end
            default:
            begin
                want = '0;
            end
        endcase
        return want;
    endfunction

    // The receiver decides at every falling edge whether to hold off the
    // result for the next rising edge.
    always @(negedge clk)
    begin
        res_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    // Both handshakes are observed at the rising edge. The result side is
    // checked before the new prediction is queued; an item passes the input and
    // result registers before it is offered, so the two never share an item.
    always @(posedge clk)
    begin
        res_item_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (digit_results_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("unexpected result item: result=%h flag=%b",
                                 res.result, res.flag_out);
                    end
                end
                else
                begin
                    want = digit_results_due.pop_front();
                    if (res.result !== want.result || res.flag_out !== want.flag_out)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                        begin
                            $display("mismatch: expected result=%h flag=%b, got result=%h flag=%b",
                                     want.result, want.flag_out, res.result, res.flag_out);
                        end
                    end
                end
            end
            if (op_valid && !op_stall)
            begin
                digit_results_due.push_back(expected_digit_result(op));
            end
        end
    end

    // A run that never drains ends here as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offers one operation item and returns once the ALU has taken it. Gaps
    // are inserted before the item, and valid is written only once per
    // falling edge, so back-to-back items keep valid high throughout.
    task automatic send_digit_op(input logic [2:0] mode, input logic [7:0] operand_a,
                                 input logic [7:0] operand_b, input logic carry_in);
        op_item_t item;
        item.mode      = mode;
        item.operand_a = operand_a;
        item.operand_b = operand_b;
        item.carry_in  = carry_in;
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            op_valid <= 1'b0;
            @(negedge clk);
        end
        op_valid <= 1'b1;
        op       <= item;
        @(posedge clk);
        while (op_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_traffic(input int idle_pct, input int stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
    endtask

    // Digit add: zero, a sum of exactly nine, the first sum that needs the
    // decimal adjust, the largest decimal case, non-decimal nibbles, and
    // junk in the upper nibbles that must be ignored.
    task automatic test_bcd_add();
        send_digit_op(MODE_BCD_ADD, 8'h00, 8'h00, 1'b0);
        send_digit_op(MODE_BCD_ADD, 8'h05, 8'h04, 1'b0);
        send_digit_op(MODE_BCD_ADD, 8'h05, 8'h04, 1'b1);
        send_digit_op(MODE_BCD_ADD, 8'h09, 8'h09, 1'b1);
        send_digit_op(MODE_BCD_ADD, 8'hFF, 8'hFF, 1'b1);
        send_digit_op(MODE_BCD_ADD, 8'hA3, 8'h5C, 1'b0);
    endtask

    // Digit subtract: borrow in alone, no borrow at all, a plain borrow,
    // a non-decimal result when no borrow is taken, and the deepest borrow.
    task automatic test_bcd_sub();
        send_digit_op(MODE_BCD_SUB, 8'h00, 8'h00, 1'b1);
        send_digit_op(MODE_BCD_SUB, 8'h09, 8'h00, 1'b0);
        send_digit_op(MODE_BCD_SUB, 8'h03, 8'h07, 1'b0);
        send_digit_op(MODE_BCD_SUB, 8'hCF, 8'h30, 1'b0);
        send_digit_op(MODE_BCD_SUB, 8'hF0, 8'hFF, 1'b1);
    endtask

    // Digit multiply: the largest decimal product, a product of a hundred or
    // more that loses its hundreds digit, a plain product, zero, and ignored upper nibbles.
    task automatic test_bcd_mul();
        send_digit_op(MODE_BCD_MUL, 8'h09, 8'h09, 1'b1);
        send_digit_op(MODE_BCD_MUL, 8'h0F, 8'h0F, 1'b0);
        send_digit_op(MODE_BCD_MUL, 8'h07, 8'h08, 1'b0);
        send_digit_op(MODE_BCD_MUL, 8'h00, 8'h05, 1'b0);
        send_digit_op(MODE_BCD_MUL, 8'hF1, 8'hE9, 1'b1);
    endtask

    // Exponent add and subtract at both ends of the byte, including the
    // wrap in each direction; the carry bit must be ignored.
    task automatic test_exponent_ops();
        send_digit_op(MODE_EXP_ADD, 8'hFF, 8'hFF, 1'b1);
        send_digit_op(MODE_EXP_ADD, 8'h00, 8'h00, 1'b0);
        send_digit_op(MODE_EXP_ADD, 8'h80, 8'h80, 1'b0);
        send_digit_op(MODE_EXP_SUB, 8'h00, 8'hFF, 1'b1);
        send_digit_op(MODE_EXP_SUB, 8'hFF, 8'h00, 1'b0);
    endtask

    // The spare codes return zero whatever the operands hold.
    task automatic test_unused_modes();
        logic [2:0] mode;
        for (mode = MODE_UNUSED_FIRST; mode != MODE_BCD_ADD; mode++)
        begin
            send_digit_op(mode, 8'hFF, 8'hFF, 1'b1);
        end
    endtask

    // Random items. Most pick one of the five real operations; a few use
    // a spare code. In half of the items both operands get a decimal low
    // nibble so the BCD paths spend most of their time on legal digits,
    // with random upper bits in every case.
    task automatic test_random_ops(input int count);
        logic [2:0] mode;
        logic [7:0] operand_a;
        logic [7:0] operand_b;
        int         n;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 95)
            begin
                mode = 3'($urandom_range(MODE_BCD_ADD, MODE_EXP_SUB));
            end
            else
            begin
                mode = 3'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
            end
            operand_a = 8'($urandom_range(0, 255));
            operand_b = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 1)
            begin
                operand_a[3:0] = 4'($urandom_range(0, 9));
                operand_b[3:0] = 4'($urandom_range(0, 9));
            end
            send_digit_op(mode, operand_a, operand_b, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        op_valid  = 1'b0;
        op        = '0;
        res_stall = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed items go in back to back with no stalls.
        set_traffic(0, 0);
        test_bcd_add();
        test_bcd_sub();
        test_bcd_mul();
        test_exponent_ops();
        test_unused_modes();

        // Random items under each traffic shape in turn.
        test_random_ops(RANDOM_PER_PHASE);
        set_traffic(62, 0);
        test_random_ops(RANDOM_PER_PHASE);
        set_traffic(0, 62);
        test_random_ops(RANDOM_PER_PHASE);
        set_traffic(12, 12);
        test_random_ops(RANDOM_PER_PHASE);

        @(negedge clk);
        op_valid <= 1'b0;

        // Let every result drain, then keep watching for strays.
        while (digit_results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
